FILE: rtl/rdm_responder_parameter_handler_defines.svh
// ----------------------------------------------------------------------------
// RDM responder parameter handler - assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef RDM_RESPONDER_PARAMETER_HANDLER_DEFINES_SVH
`define RDM_RESPONDER_PARAMETER_HANDLER_DEFINES_SVH
`ifndef SYNTHESIS
`define RDM_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("rdm_rsp: assertion failed");
`define RDM_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
        else $error("rdm_rsp: forbidden condition");
`else
`define RDM_ASSERT(lbl, clk_s, rst_s, prop)
`define RDM_ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`endif
`endif

FILE: rtl/rdm_rsp_pkg.sv
// ----------------------------------------------------------------------------
// rdm_rsp_pkg
// Shared types, constants and response byte tables of the RDM responder.
// ----------------------------------------------------------------------------
package rdm_rsp_pkg;

    localparam int NUM_PERSONALITIES = 3;
    localparam int UNIVERSE_SLOTS    = 512;
    localparam int TABLE_PERS        = 3;
    localparam int PERS_LIMIT        = (NUM_PERSONALITIES < TABLE_PERS) ?
                                       NUM_PERSONALITIES : TABLE_PERS;
    localparam int RSP_QUEUE_DEPTH   = 4;

    localparam logic [7:0]  NUM_PERS_BYTE = 8'(NUM_PERSONALITIES);
    localparam logic [16:0] SLOTS_END     = 17'(UNIVERSE_SLOTS + 1);

    // parameter IDs
    localparam logic [15:0] PID_SUPPORTED  = 16'h0050;
    localparam logic [15:0] PID_DEVINFO    = 16'h0060;
    localparam logic [15:0] PID_PRODLIST   = 16'h0070;
    localparam logic [15:0] PID_MODEL      = 16'h0080;
    localparam logic [15:0] PID_MFR        = 16'h0081;
    localparam logic [15:0] PID_LABEL      = 16'h0082;
    localparam logic [15:0] PID_SWVER      = 16'h00C0;
    localparam logic [15:0] PID_PERSONALITY = 16'h00E0;
    localparam logic [15:0] PID_PERS_DESC  = 16'h00E1;
    localparam logic [15:0] PID_START_ADDR = 16'h00F0;
    localparam logic [15:0] PID_IDENTIFY   = 16'h1000;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_TIMEOUT,
        ST_BCAST
    } status_t;

    typedef enum logic [2:0] {
        NR_UNKNOWN,
        NR_FORMAT,
        NR_CLASS,
        NR_RANGE,
        NR_SUBDEV
    } nack_reason_t;

    typedef enum logic [3:0] {
        RK_NONE,
        RK_SUPPORTED,
        RK_DEVINFO,
        RK_PRODLIST,
        RK_MODEL,
        RK_MFR,
        RK_LABEL,
        RK_SWVER,
        RK_PERS,
        RK_PERSDESC,
        RK_ADDR,
        RK_IDENT
    } rsp_kind_t;

    typedef struct packed {
        status_t      status;
        logic         is_nack;
        nack_reason_t reason;
        rsp_kind_t    kind;
        logic [1:0]   pers;
        logic [9:0]   start_addr;
        logic         ident;
    } rsp_desc_t;

    localparam int SUPP_LEN  = 12;
    localparam int DEV_LEN   = 19;
    localparam int PROD_LEN  = 4;
    localparam int MODEL_LEN = 11;
    localparam int MFR_LEN   = 13;
    localparam int LABEL_LEN = 16;
    localparam int SWVER_LEN = 22;
    localparam int PSTR_LEN  = 12;
    localparam int DESC_LEN  = 35;

    localparam logic [8*SUPP_LEN-1:0]  SUPP_BYTES = 96'h0082_0080_00E0_00E1_0081_0070;
    localparam logic [8*PROD_LEN-1:0]  PROD_BYTES = 32'h0900_7FFF;
    localparam logic [8*MODEL_LEN-1:0] MODEL_STR  = "Dummy Model";
    localparam logic [8*MFR_LEN-1:0]   MFR_STR    = 104'h4F70656E204C69676874696E67;
    localparam logic [8*LABEL_LEN-1:0] LABEL_STR  = "Dummy RDM Device";
    localparam logic [8*SWVER_LEN-1:0] SWVER_STR  = "Dummy Software Version";
    localparam logic [8*PSTR_LEN-1:0]  PERS_STR   = "Personality ";

    function automatic logic [15:0] footprint(input logic [1:0] p);
        logic [15:0] fp;
        case (p)
            2'd0:    fp = 16'd5;
            2'd1:    fp = 16'd10;
            2'd2:    fp = 16'd20;
            default: fp = 16'd0;
        endcase
        return fp;
    endfunction

    function automatic logic [5:0] rsp_len(input rsp_kind_t kind);
        logic [5:0] n;
        case (kind)
            RK_SUPPORTED: n = 6'(SUPP_LEN);
            RK_DEVINFO:   n = 6'(DEV_LEN);
            RK_PRODLIST:  n = 6'(PROD_LEN);
            RK_MODEL:     n = 6'(MODEL_LEN);
            RK_MFR:       n = 6'(MFR_LEN);
            RK_LABEL:     n = 6'(LABEL_LEN);
            RK_SWVER:     n = 6'(SWVER_LEN);
            RK_PERS:      n = 6'd2;
            RK_PERSDESC:  n = 6'(DESC_LEN);
            RK_ADDR:      n = 6'd2;
            RK_IDENT:     n = 6'd1;
            default:      n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] rsp_byte(input rsp_desc_t d, input logic [5:0] idx);
        logic [7:0]  b;
        logic [15:0] fp;
        logic [7:0]  pnum;
        int          i;
        i    = int'(idx);
        fp   = footprint(d.pers);
        pnum = {6'b0, d.pers};
        b    = 8'h00;
        case (d.kind)
            RK_SUPPORTED: b = SUPP_BYTES[8*(SUPP_LEN-1-i) +: 8];
            RK_PRODLIST:  b = PROD_BYTES[8*(PROD_LEN-1-i) +: 8];
            RK_MODEL:     b = MODEL_STR[8*(MODEL_LEN-1-i) +: 8];
            RK_MFR:       b = MFR_STR[8*(MFR_LEN-1-i) +: 8];
            RK_LABEL:     b = LABEL_STR[8*(LABEL_LEN-1-i) +: 8];
            RK_SWVER:     b = SWVER_STR[8*(SWVER_LEN-1-i) +: 8];
            RK_DEVINFO:
            begin
                case (idx)
                    6'd0:    b = 8'h01;
                    6'd3:    b = 8'h01;
                    6'd4:    b = 8'h7F;
                    6'd5:    b = 8'hFF;
                    6'd9:    b = 8'h01;
                    6'd10:   b = fp[15:8];
                    6'd11:   b = fp[7:0];
                    6'd12:   b = pnum + 8'd1;
                    6'd13:   b = NUM_PERS_BYTE;
                    6'd14:   b = {6'b0, d.start_addr[9:8]};
                    6'd15:   b = d.start_addr[7:0];
                    default: b = 8'h00;
                endcase
            end
            RK_PERS:      b = (idx == 6'd0) ? pnum + 8'd1 : NUM_PERS_BYTE;
            RK_PERSDESC:
            begin
                if (idx == 6'd0)
                begin
                    b = pnum + 8'd1;
                end
                else if (idx == 6'd1)
                begin
                    b = fp[15:8];
                end
                else if (idx == 6'd2)
                begin
                    b = fp[7:0];
                end
                else if (idx < 6'(PSTR_LEN + 3))
                begin
                    b = PERS_STR[8*(PSTR_LEN+2-i) +: 8];
                end
                else if (idx == 6'(PSTR_LEN + 3))
                begin
                    b = 8'h31 + pnum;
                end
            end
            RK_ADDR:      b = (idx == 6'd0) ? {6'b0, d.start_addr[9:8]} : d.start_addr[7:0];
            RK_IDENT:     b = {7'b0, d.ident};
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/rdm_responder_parameter_handler.sv
// ----------------------------------------------------------------------------
// rdm_responder_parameter_handler
// RDM responder: checks and answers decoded requests, one response byte per
// result.
//
//   port group   handshake             payload
//   cfg          cfg_wr_en             cfg_wr_data (device UID)
//   in           in_valid / in_ready   dest_uid .. data_word
//   out          out_valid / out_ready status .. last
//
// A request is classified and its state update applied in the cycle it is
// accepted; the front takes one request per cycle while the queue has room.
// The back sequencer emits one result per cycle unless the output stalls:
// one for a request without data, else one per response byte, at most 35.
// Reset: UID 0, personality 1, start address 1, identify off, queue empty.
// A stalled output holds the back; the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
module rdm_responder_parameter_handler #(
    parameter int QUEUE_DEPTH = rdm_rsp_pkg::RSP_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [47:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] dest_uid,
    input  logic        action,
    input  logic [15:0] sub_device,
    input  logic [15:0] param_id,
    input  logic [7:0]  data_length,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        is_nack,
    output logic [2:0]  nack_reason,
    output logic        has_data,
    output logic [7:0]  data_byte,
    output logic        last
);
    import rdm_rsp_pkg::*;

    rsp_desc_t push_desc, head_desc;
    logic      push, pop, queue_full, queue_empty;

    rdm_rsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dest_uid    (dest_uid),
        .action      (action),
        .sub_device  (sub_device),
        .param_id    (param_id),
        .data_length (data_length),
        .data_word   (data_word),
        .push        (push),
        .push_desc   (push_desc),
        .queue_full  (queue_full)
    );

    rdm_rsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (queue_empty)
    );

    rdm_rsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_desc   (head_desc),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .is_nack     (is_nack),
        .nack_reason (nack_reason),
        .has_data    (has_data),
        .data_byte   (data_byte),
        .last        (last)
    );

endmodule

FILE: rtl/rdm_rsp_front.sv
// ----------------------------------------------------------------------------
// rdm_rsp_front
// Address check, parameter dispatch, validation and state updates.
// ----------------------------------------------------------------------------
`include "rdm_responder_parameter_handler_defines.svh"

module rdm_rsp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [47:0]            cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [47:0]            dest_uid,
    input  logic                   action,
    input  logic [15:0]            sub_device,
    input  logic [15:0]            param_id,
    input  logic [7:0]             data_length,
    input  logic [15:0]            data_word,
    output logic                   push,
    output rdm_rsp_pkg::rsp_desc_t push_desc,
    input  logic                   queue_full
);
    import rdm_rsp_pkg::*;

    logic [47:0] uid_reg;
    logic [1:0]  pers_reg, pers_next;
    logic [9:0]  sa_reg, sa_next;
    logic        ident_reg, ident_next;

    logic        uid_hit, bcast, p_ok, bad, late;
    logic [7:0]  p;
    nack_reason_t nr;
    rsp_desc_t   d;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign uid_hit  = (dest_uid == uid_reg);
    assign bcast    = (dest_uid[31:0] == 32'hFFFF_FFFF);
    assign p        = data_word[15:8] - 8'd1;
    assign p_ok     = (p < 8'(PERS_LIMIT));

    always_comb
    begin
        d            = '0;
        d.status     = ST_DONE;
        d.reason     = NR_UNKNOWN;
        d.kind       = RK_NONE;
        d.pers       = pers_reg;
        d.start_addr = sa_reg;
        d.ident      = ident_reg;
        pers_next    = pers_reg;
        sa_next      = sa_reg;
        ident_next   = ident_reg;
        bad          = 1'b0;
        late         = 1'b0;
        nr           = NR_UNKNOWN;
        if (!uid_hit && !bcast)
        begin
            d.status = ST_TIMEOUT;
        end
        else
        begin
            case (param_id)
                PID_SUPPORTED, PID_DEVINFO, PID_PRODLIST, PID_MODEL,
                PID_MFR, PID_LABEL, PID_SWVER:
                begin
                    if (bcast)
                    begin
                        d.status = ST_BCAST;
                    end
                    else if (action)
                    begin
                        bad = 1'b1;
                        nr  = NR_CLASS;
                    end
                    else if (sub_device != 16'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_SUBDEV;
                    end
                    else if (data_length != 8'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_FORMAT;
                    end
                    else
                    begin
                        case (param_id)
                            PID_SUPPORTED: d.kind = RK_SUPPORTED;
                            PID_DEVINFO:   d.kind = RK_DEVINFO;
                            PID_PRODLIST:  d.kind = RK_PRODLIST;
                            PID_MODEL:     d.kind = RK_MODEL;
                            PID_MFR:       d.kind = RK_MFR;
                            PID_LABEL:     d.kind = RK_LABEL;
                            default:       d.kind = RK_SWVER;
                        endcase
                    end
                end
                PID_PERSONALITY:
                begin
                    late = 1'b1;
                    if (sub_device != 16'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_SUBDEV;
                    end
                    else if (action)
                    begin
                        if (data_length != 8'd1)
                        begin
                            bad = 1'b1;
                            nr  = NR_FORMAT;
                        end
                        else if (!p_ok || (17'(sa_reg) + 17'(footprint(p[1:0])) > SLOTS_END))
                        begin
                            bad = 1'b1;
                            nr  = NR_RANGE;
                        end
                        else
                        begin
                            pers_next = p[1:0];
                        end
                    end
                    else if (data_length != 8'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_FORMAT;
                    end
                    else
                    begin
                        d.kind = RK_PERS;
                    end
                end
                PID_PERS_DESC:
                begin
                    if (bcast)
                    begin
                        d.status = ST_BCAST;
                    end
                    else if (action)
                    begin
                        bad = 1'b1;
                        nr  = NR_CLASS;
                    end
                    else if (sub_device != 16'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_SUBDEV;
                    end
                    else if (data_length != 8'd1)
                    begin
                        bad = 1'b1;
                        nr  = NR_FORMAT;
                    end
                    else if (!p_ok)
                    begin
                        bad = 1'b1;
                        nr  = NR_RANGE;
                    end
                    else
                    begin
                        d.kind = RK_PERSDESC;
                        d.pers = p[1:0];
                    end
                end
                PID_START_ADDR:
                begin
                    late = 1'b1;
                    if (sub_device != 16'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_SUBDEV;
                    end
                    else if (action)
                    begin
                        if (data_length != 8'd2)
                        begin
                            bad = 1'b1;
                            nr  = NR_FORMAT;
                        end
                        else if (data_word == 16'd0 ||
                                 (17'(data_word) + 17'(footprint(pers_reg)) > SLOTS_END))
                        begin
                            bad = 1'b1;
                            nr  = NR_RANGE;
                        end
                        else
                        begin
                            sa_next = data_word[9:0];
                        end
                    end
                    else if (data_length != 8'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_FORMAT;
                    end
                    else
                    begin
                        d.kind = RK_ADDR;
                    end
                end
                PID_IDENTIFY:
                begin
                    late = 1'b1;
                    if (sub_device != 16'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_SUBDEV;
                    end
                    else if (action)
                    begin
                        if (data_length != 8'd1)
                        begin
                            bad = 1'b1;
                            nr  = NR_FORMAT;
                        end
                        else if (data_word[15:8] > 8'd1)
                        begin
                            bad = 1'b1;
                            nr  = NR_RANGE;
                        end
                        else
                        begin
                            ident_next = data_word[8];
                        end
                    end
                    else if (data_length != 8'd0)
                    begin
                        bad = 1'b1;
                        nr  = NR_FORMAT;
                    end
                    else
                    begin
                        d.kind = RK_IDENT;
                    end
                end
                default:
                begin
                    if (bcast)
                    begin
                        d.status = ST_BCAST;
                    end
                    else
                    begin
                        bad = 1'b1;
                        nr  = NR_UNKNOWN;
                    end
                end
            endcase
            // broadcast settles after validation for settable parameters
            if (late && bcast)
            begin
                d.status = ST_BCAST;
                d.kind   = RK_NONE;
                bad      = 1'b0;
            end
            if (bad)
            begin
                d.is_nack = 1'b1;
                d.reason  = nr;
                d.kind    = RK_NONE;
            end
        end
    end

    assign push_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uid_reg   <= '0;
            pers_reg  <= 2'd0;
            sa_reg    <= 10'd1;
            ident_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                uid_reg <= cfg_wr_data;
            end
            if (push)
            begin
                pers_reg  <= pers_next;
                sa_reg    <= sa_next;
                ident_reg <= ident_next;
            end
        end
    end

    `RDM_ASSERT_NEVER(a_start_addr_nonzero, clk, rst_n, sa_reg == 10'd0)
    `RDM_ASSERT(a_pers_in_range, clk, rst_n, pers_reg < 2'(PERS_LIMIT))

endmodule

FILE: rtl/rdm_rsp_queue.sv
// ----------------------------------------------------------------------------
// rdm_rsp_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "rdm_responder_parameter_handler_defines.svh"

module rdm_rsp_queue #(
    parameter int DEPTH = rdm_rsp_pkg::RSP_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rdm_rsp_pkg::rsp_desc_t push_desc,
    output logic                   full,
    input  logic                   pop,
    output rdm_rsp_pkg::rsp_desc_t head_desc,
    output logic                   empty
);
    import rdm_rsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rsp_desc_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `RDM_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty)
    `RDM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))

endmodule

FILE: rtl/rdm_rsp_back.sv
// ----------------------------------------------------------------------------
// rdm_rsp_back
// Sequencer: one result per cycle unless stalled, queue head to output register.
// ----------------------------------------------------------------------------
`include "rdm_responder_parameter_handler_defines.svh"

module rdm_rsp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rdm_rsp_pkg::rsp_desc_t head_desc,
    input  logic                   empty,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic                   is_nack,
    output logic [2:0]             nack_reason,
    output logic                   has_data,
    output logic [7:0]             data_byte,
    output logic                   last
);
    import rdm_rsp_pkg::*;

    logic [5:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg;
    logic       is_nack_reg, has_data_reg, last_reg;
    logic [2:0] reason_reg;
    logic [7:0] byte_reg;

    logic [5:0] len;
    logic       single_item, item_last, load;

    assign len         = rsp_len(head_desc.kind);
    assign single_item = (head_desc.kind == RK_NONE);
    assign item_last   = single_item || (idx_reg == len - 6'd1);
    assign load        = !empty && (!out_valid_reg || out_ready);
    assign pop         = load && item_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = item_last ? 6'd0 : idx_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg   <= head_desc.status;
            is_nack_reg  <= head_desc.is_nack;
            reason_reg   <= head_desc.reason;
            has_data_reg <= !single_item;
            byte_reg     <= single_item ? 8'h00 : rsp_byte(head_desc, idx_reg);
            last_reg     <= item_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign is_nack     = is_nack_reg;
    assign nack_reason = reason_reg;
    assign has_data    = has_data_reg;
    assign data_byte   = byte_reg;
    assign last        = last_reg;

    `RDM_ASSERT(a_idx_restart, clk, rst_n, pop |=> idx_reg == 6'd0)

endmodule
